/* sv/alm_pkg.sv */
// ---------------------------------------------------------------------------
// alm_pkg
// Shared types and constants of the audio level meter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

   localparam int MAX_WINDOW_DEF     = 256;
   localparam int LOG_TABLE_BITS_DEF = 8;

   localparam int ONE_Q16         = 65536;
   localparam int LEVEL_41_42     = 63976;
   localparam int DB_PER_LOG2_Q16 = 394566;
   localparam int FLOOR_DB_Q16    = -6553600;
   localparam int IEC_DIVISOR     = 400;
   localparam int IEC_ROUND       = 200;

   localparam int CSR_W       = 9;
   localparam int LEVEL_W     = 24;
   localparam int CHANNEL_W   = 8;
   localparam int SAMPLE_W    = 32;
   localparam int MAG_W       = 31;

   typedef enum logic [1:0] {
      CSR_PEAK_MODE    = 2'd0,
      CSR_IEC_ENABLE   = 2'd1,
      CSR_WINDOW_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      LATCH_NONE = 2'd0,
      LATCH_HIGH = 2'd1,
      LATCH_FULL = 2'd2
   } latch_type;

   typedef struct packed {
      logic [MAG_W-1:0]     peak;
      latch_type            latched;
      logic [CHANNEL_W-1:0] channel;
      logic                 peak_mode;
      logic                 iec_enable;
   } win_info_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_NORM,
      ST_LOG,
      ST_LOG2,
      ST_DBMUL,
      ST_DBFIN,
      ST_IEC,
      ST_IECDIV,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

/* sv/alm_front.sv */
// ---------------------------------------------------------------------------
// alm_front
// Accepts sample words, keeps window peak, sum and over-scale run, and
// pushes a window summary on the last word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alm_front #(
   parameter int MAX_WINDOW = alm_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [alm_pkg::SAMPLE_W-1:0] req_sample_value,
   input  wire logic [alm_pkg::CHANNEL_W-1:0]       req_channel,
   input  wire logic                                req_last_sample,
   input  wire logic                                csr_write_enable,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [alm_pkg::CSR_W-1:0]           csr_write_data,
   output logic                                     push_valid,
   input  wire logic                                push_ready,
   output alm_pkg::win_info_type                    win_info,
   output logic [31+$clog2(MAX_WINDOW+1)-1:0]       win_sum,
   output logic [$clog2(MAX_WINDOW+1)-1:0]          win_count
);

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int SW = 31 + CW;

   logic                        peak_mode_ff;
   logic                        iec_enable_ff;
   logic [alm_pkg::CSR_W-1:0]   limit_ff;

   logic [alm_pkg::MAG_W-1:0]   peak_ff, peak_in;
   logic [SW-1:0]               sum_ff, sum_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [3:0]                  run_ff, run_in;
   alm_pkg::latch_type          latch_ff, latch_in;

   logic [alm_pkg::SAMPLE_W-1:0] neg;
   logic [alm_pkg::MAG_W-1:0]    mag;
   logic                         counts;
   logic                         accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_mode_ff  <= 1'b0;
         iec_enable_ff <= 1'b1;
         limit_ff      <= 9'd200;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            alm_pkg::CSR_PEAK_MODE:    peak_mode_ff  <= csr_write_data[0];
            alm_pkg::CSR_IEC_ENABLE:   iec_enable_ff <= csr_write_data[0];
            alm_pkg::CSR_WINDOW_LIMIT: limit_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      neg = ~req_sample_value + 32'd1;
      if (!req_sample_value[31])
         mag = req_sample_value[30:0];
      else if (neg[31])
         mag = 31'h7FFF_FFFF;
      else
         mag = neg[30:0];

      counts = (32'(count_ff) < 32'(limit_ff)) && (32'(count_ff) < 32'(MAX_WINDOW));

      peak_in  = peak_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      run_in   = run_ff;
      latch_in = latch_ff;
      if (counts) begin
         count_in = count_ff + CW'(1);
         if (mag > peak_ff)
            peak_in = mag;
         if (latch_ff != alm_pkg::LATCH_FULL) begin
            sum_in = sum_ff + SW'(mag);
            // full scale is 1.0 in Q28
            if (mag[30:28] != 3'd0)
               run_in = (run_ff == 4'd15) ? 4'd15 : run_ff + 4'd1;
            else
               run_in = 4'd0;
            if (run_in > 4'd10)
               latch_in = alm_pkg::LATCH_FULL;
            else if (run_in > 4'd3)
               latch_in = alm_pkg::LATCH_HIGH;
         end
      end

      push_valid          = accept && req_last_sample;
      win_info.peak       = peak_in;
      win_info.latched    = latch_in;
      win_info.channel    = req_channel;
      win_info.peak_mode  = peak_mode_ff;
      win_info.iec_enable = iec_enable_ff;
      win_sum             = sum_in;
      win_count           = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         run_ff   <= '0;
         latch_ff <= alm_pkg::LATCH_NONE;
      end else if (accept) begin
         if (req_last_sample) begin
            peak_ff  <= '0;
            sum_ff   <= '0;
            count_ff <= '0;
            run_ff   <= '0;
            latch_ff <= alm_pkg::LATCH_NONE;
         end else begin
            peak_ff  <= peak_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
            run_ff   <= run_in;
            latch_ff <= latch_in;
         end
      end
   end

endmodule

`default_nettype wire

/* sv/alm_fifo.sv */
// ---------------------------------------------------------------------------
// alm_fifo
// Two-entry queue of window summaries between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alm_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       fill_ff;
   logic             push;
   logic             pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push)
            wr_ff <= ~wr_ff;
         if (pop)
            rd_ff <= ~rd_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

`default_nettype wire

/* sv/alm_div.sv */
// ---------------------------------------------------------------------------
// alm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alm_div #(
   parameter int NW = 46,
   parameter int DW = 15
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo
);

   localparam int KW = $clog2(NW + 1);

   logic [DW:0]   rem_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] den_ff;
   logic [KW-1:0] left_ff;
   logic          done_ff;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff[DW-1:0], quo_ff[NW-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (left_ff != '0) begin
         rem_ff <= fits ? trial - {1'b0, den_ff} : trial;
         quo_ff <= {quo_ff[NW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (left_ff == KW'(1));
         if (start)
            left_ff <= KW'(NW);
         else if (left_ff != '0)
            left_ff <= left_ff - KW'(1);
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

/* sv/alm_back.sv */
// ---------------------------------------------------------------------------
// alm_back
// Turns a window summary into a level: mean or peak, log2, dB and IEC curve,
// and holds the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alm_back #(
   parameter int MAX_WINDOW     = alm_pkg::MAX_WINDOW_DEF,
   parameter int LOG_TABLE_BITS = alm_pkg::LOG_TABLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pop_valid,
   output logic                                     pop_ready,
   input  wire alm_pkg::win_info_type               win_info,
   input  wire logic [31+$clog2(MAX_WINDOW+1)-1:0]  win_sum,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]     win_count,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [alm_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [alm_pkg::CHANNEL_W-1:0]            rsp_level_channel
);

   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int SW    = 31 + CW;
   localparam int NW    = SW + 6;
   localparam int DW    = (CW + 6 > 9) ? CW + 6 : 9;
   localparam int B     = LOG_TABLE_BITS;
   localparam int TAB_N = 1 << B;

   // ceil(2^26 / 25): exact quotient by 25 for any dividend below 2^21
   localparam logic [21:0] IEC_RECIP = 22'd2684355;

   typedef logic [16:0] tab_type [TAB_N+1];

   function automatic tab_type build_tab();
      tab_type     t;
      logic [63:0] m;
      logic [16:0] y;
      for (int i = 0; i < TAB_N; i++) begin
         m = (64'd1 << 30) + (64'(i) << (30 - B));
         y = '0;
         for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               y[k] = 1'b1;
            end
         end
         t[i] = y;
      end
      t[TAB_N] = 17'(alm_pkg::ONE_Q16);
      return t;
   endfunction

   localparam tab_type LOG_TAB = build_tab();

   alm_pkg::back_state_type state_ff, state_in;

   logic                            iec_ff, iec_in;
   logic [alm_pkg::CHANNEL_W-1:0]   chan_ff, chan_in;
   logic [31:0]                     x_ff, x_in;
   logic [4:0]                      p_ff, p_in;
   logic                            f28_ff, f28_in;
   logic [16:0]                     lo_ff, lo_in;
   logic [32:0]                     prod_ff, prod_in;
   logic signed [22:0]              l_ff, l_in;
   logic signed [43:0]              dprod_ff, dprod_in;
   logic signed [23:0]              d_ff, d_in;
   logic signed [23:0]              res_ff, res_in;
   logic                            rsp_valid_ff;
   logic signed [23:0]              rsp_level_ff;
   logic [alm_pkg::CHANNEL_W-1:0]   rsp_chan_ff;

   logic                            div_start;
   logic [NW-1:0]                   div_num;
   logic [DW-1:0]                   div_den;
   logic                            div_done;
   logic [NW-1:0]                   div_quo;

   logic                            have_lev;
   logic [23:0]                     lev;
   logic                            out_load;
   logic [B-1:0]                    idx;
   logic [B:0]                      idx_hi;
   logic [15:0]                     frac;
   logic [16:0]                     diff;
   logic [21:0]                     log_u;
   logic [43:0]                     dmag;
   logic [43:0]                     rnd;
   logic signed [43:0]              dr;
   logic signed [27:0]              dd;
   logic signed [27:0]              n;
   logic [24:0]                     v;
   logic [42:0]                     iec_prod;

   alm_div #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= alm_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      iec_in    = iec_ff;
      chan_in   = chan_ff;
      x_in      = x_ff;
      p_in      = p_ff;
      f28_in    = f28_ff;
      lo_in     = lo_ff;
      prod_in   = prod_ff;
      l_in      = l_ff;
      dprod_in  = dprod_ff;
      d_in      = d_ff;
      res_in    = res_ff;
      pop_ready = 1'b0;
      div_start = 1'b0;
      div_num   = NW'(win_sum) * NW'(40);
      div_den   = DW'(win_count) * DW'(42);
      have_lev  = 1'b0;
      lev       = '0;
      out_load  = 1'b0;

      idx    = x_ff[30 -: B];
      idx_hi = {1'b0, idx} + (B+1)'(1);
      frac   = x_ff[30-B -: 16];
      diff   = LOG_TAB[idx_hi] - LOG_TAB[idx];
      log_u  = {1'b0, p_ff, 16'd0} + 22'(lo_ff) + 22'(prod_ff[32:16]);

      dmag = 44'(-dprod_ff);
      if (dprod_ff < 0) begin
         rnd = (dmag + 44'd32768) >> 16;
         dr  = -$signed(rnd);
      end else begin
         rnd = (44'(dprod_ff) + 44'd32768) >> 16;
         dr  = $signed(rnd);
      end

      // IEC curve segments, numerator over 400
      dd = 28'(d_ff);
      if (dd < -28'sd70 * 28'sd65536)
         n = '0;
      else if (dd < -28'sd60 * 28'sd65536)
         n = dd + 28'sd70 * 28'sd65536;
      else if (dd < -28'sd50 * 28'sd65536)
         n = 28'sd2 * (dd + 28'sd60 * 28'sd65536) + 28'sd10 * 28'sd65536;
      else if (dd < -28'sd40 * 28'sd65536)
         n = 28'sd3 * (dd + 28'sd50 * 28'sd65536) + 28'sd30 * 28'sd65536;
      else if (dd < -28'sd30 * 28'sd65536)
         n = 28'sd6 * (dd + 28'sd40 * 28'sd65536) + 28'sd60 * 28'sd65536;
      else if (dd < -28'sd20 * 28'sd65536)
         n = 28'sd8 * (dd + 28'sd30 * 28'sd65536) + 28'sd120 * 28'sd65536;
      else
         n = 28'sd10 * (dd + 28'sd20 * 28'sd65536) + 28'sd200 * 28'sd65536;
      v = n[24:0] + 25'(alm_pkg::IEC_ROUND);

      // divide by 400: drop four bits, then multiply by the reciprocal of 25
      iec_prod = 43'(x_ff[24:4]) * 43'(IEC_RECIP);

      unique case (state_ff)
         alm_pkg::ST_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               iec_in    = win_info.iec_enable;
               chan_in   = win_info.channel;
               if (win_info.peak_mode) begin
                  if (win_info.peak == '0) begin
                     d_in     = 24'(alm_pkg::FLOOR_DB_Q16);
                     res_in   = 24'(alm_pkg::FLOOR_DB_Q16);
                     state_in = win_info.iec_enable ? alm_pkg::ST_IEC : alm_pkg::ST_OUT;
                  end else begin
                     x_in     = {1'b0, win_info.peak};
                     p_in     = 5'd31;
                     f28_in   = 1'b1;
                     state_in = alm_pkg::ST_NORM;
                  end
               end else begin
                  priority if (win_info.latched == alm_pkg::LATCH_FULL) begin
                     have_lev = 1'b1;
                     lev      = 24'(alm_pkg::ONE_Q16);
                  end else if (win_info.latched == alm_pkg::LATCH_HIGH) begin
                     have_lev = 1'b1;
                     lev      = 24'(alm_pkg::LEVEL_41_42);
                  end else if (win_count == '0) begin
                     have_lev = 1'b1;
                     lev      = '0;
                  end else begin
                     div_start = 1'b1;
                     state_in  = alm_pkg::ST_DIV;
                  end
               end
            end
         end
         alm_pkg::ST_DIV: begin
            if (div_done) begin
               have_lev = 1'b1;
               lev      = div_quo[12 +: 24];
            end
         end
         alm_pkg::ST_NORM: begin
            // shift until the leading one sits at the top
            if (x_ff[31])
               state_in = alm_pkg::ST_LOG;
            else begin
               x_in = {x_ff[30:0], 1'b0};
               p_in = p_ff - 5'd1;
            end
         end
         alm_pkg::ST_LOG: begin
            lo_in    = LOG_TAB[idx];
            prod_in  = 33'(diff) * 33'(frac);
            state_in = alm_pkg::ST_LOG2;
         end
         alm_pkg::ST_LOG2: begin
            l_in     = $signed({1'b0, log_u})
                       - (f28_ff ? 23'sd1835008 : 23'sd1048576);
            state_in = alm_pkg::ST_DBMUL;
         end
         alm_pkg::ST_DBMUL: begin
            dprod_in = 44'(l_ff) * 44'sd394566;
            state_in = alm_pkg::ST_DBFIN;
         end
         alm_pkg::ST_DBFIN: begin
            if (dr < 44'(alm_pkg::FLOOR_DB_Q16))
               d_in = 24'(alm_pkg::FLOOR_DB_Q16);
            else
               d_in = dr[23:0];
            res_in   = d_in;
            state_in = iec_ff ? alm_pkg::ST_IEC : alm_pkg::ST_OUT;
         end
         alm_pkg::ST_IEC: begin
            if (dd >= 28'sd0) begin
               res_in   = 24'(alm_pkg::ONE_Q16);
               state_in = alm_pkg::ST_OUT;
            end else if (dd < -28'sd70 * 28'sd65536) begin
               res_in   = '0;
               state_in = alm_pkg::ST_OUT;
            end else begin
               x_in     = 32'(v);
               state_in = alm_pkg::ST_IECDIV;
            end
         end
         alm_pkg::ST_IECDIV: begin
            res_in   = 24'(iec_prod[42:26]);
            state_in = alm_pkg::ST_OUT;
         end
         alm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = alm_pkg::ST_IDLE;
            end
         end
         default: state_in = alm_pkg::ST_IDLE;
      endcase

      // a plain level goes out as is, or on to the dB and IEC path
      if (have_lev) begin
         if (!iec_in) begin
            res_in   = lev;
            state_in = alm_pkg::ST_OUT;
         end else if (lev == '0) begin
            res_in   = '0;
            state_in = alm_pkg::ST_OUT;
         end else begin
            x_in     = 32'(lev);
            p_in     = 5'd31;
            f28_in   = 1'b0;
            state_in = alm_pkg::ST_NORM;
         end
      end
   end

   always_ff @(posedge clock) begin
      iec_ff   <= iec_in;
      chan_ff  <= chan_in;
      x_ff     <= x_in;
      p_ff     <= p_in;
      f28_ff   <= f28_in;
      lo_ff    <= lo_in;
      prod_ff  <= prod_in;
      l_ff     <= l_in;
      dprod_ff <= dprod_in;
      d_ff     <= d_in;
      res_ff   <= res_in;
      if (out_load) begin
         rsp_level_ff <= res_ff;
         rsp_chan_ff  <= chan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level         = rsp_level_ff;
   assign rsp_level_channel = rsp_chan_ff;

endmodule

`default_nettype wire

/* sv/audio_level_meter.sv */
// ---------------------------------------------------------------------------
// audio_level_meter
// Window level meter: peak dB or mean level, with IEC scale.
// ---------------------------------------------------------------------------
//  port group   direction   transfer
//  req_*        in          one sample word per valid/ready handshake
//  rsp_*        out         one level word per window, valid/ready
//  csr_*        in          register write on csr_write_enable, no wait
//
//  Samples: one word per cycle (front accumulator) while the queue has room.
//  Window end: the back runs a divider pass for the mean, a normalize loop,
//  4 log/dB steps, 2 IEC steps and the output load; the divider pass and
//  the normalize loop set how long a window end takes in the back.
//  A two-entry summary queue lets the front keep taking samples meanwhile.
//  Reset is synchronous; no clearing pass. A full queue stalls req_ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_level_meter #(
   parameter int MAX_WINDOW     = alm_pkg::MAX_WINDOW_DEF,
   parameter int LOG_TABLE_BITS = alm_pkg::LOG_TABLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [alm_pkg::SAMPLE_W-1:0] req_sample_value,
   input  wire logic [alm_pkg::CHANNEL_W-1:0]       req_channel,
   input  wire logic                                req_last_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [alm_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [alm_pkg::CHANNEL_W-1:0]            rsp_level_channel,
   input  wire logic                                csr_write_enable,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [alm_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int SW = 31 + CW;
   localparam int QW = $bits(alm_pkg::win_info_type) + SW + CW;

   logic                  push_valid;
   logic                  push_ready;
   alm_pkg::win_info_type push_info;
   logic [SW-1:0]         push_sum;
   logic [CW-1:0]         push_count;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [QW-1:0]         pop_data;
   alm_pkg::win_info_type pop_info;
   logic [SW-1:0]         pop_sum;
   logic [CW-1:0]         pop_count;

   alm_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_channel      (req_channel),
      .req_last_sample  (req_last_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .win_info         (push_info),
      .win_sum          (push_sum),
      .win_count        (push_count)
   );

   alm_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_info, push_sum, push_count}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_info, pop_sum, pop_count} = pop_data;

   alm_back #(
      .MAX_WINDOW     (MAX_WINDOW),
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .win_info          (pop_info),
      .win_sum           (pop_sum),
      .win_count         (pop_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level         (rsp_level),
      .rsp_level_channel (rsp_level_channel)
   );

endmodule

`default_nettype wire

/* tb/tb_audio_level_meter.sv */
// ---------------------------------------------------------------------------
// tb_audio_level_meter
// Self-checking bench for the audio level meter. Sample words are driven
// from a queue with random gaps; a built-in level predictor computes the
// expected level of each window, and every level word is compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_audio_level_meter;

   typedef struct {
      logic signed [alm_pkg::SAMPLE_W-1:0] sample;
      logic [alm_pkg::CHANNEL_W-1:0]       channel;
      logic                                last;
   } sample_word_type;

   typedef struct {
      logic [alm_pkg::LEVEL_W-1:0]   level;
      logic [alm_pkg::CHANNEL_W-1:0] channel;
   } level_word_type;

   localparam int TAB_N = 1 << alm_pkg::LOG_TABLE_BITS_DEF;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [alm_pkg::SAMPLE_W-1:0] req_sample_value = '0;
   logic [alm_pkg::CHANNEL_W-1:0] req_channel = '0;
   logic req_last_sample = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [alm_pkg::LEVEL_W-1:0] rsp_level;
   logic [alm_pkg::CHANNEL_W-1:0] rsp_level_channel;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [alm_pkg::CSR_W-1:0] csr_write_data = '0;

   sample_word_type pending_samples[$];
   level_word_type  expected_levels[$];
   int mismatches = 0;
   bit gaps_on = 1;

   // predictor copy of registers and window state
   bit          mode_peak;
   bit          mode_iec;
   int unsigned win_limit;
   bit [31:0]   peak_mag;
   bit [63:0]   mag_sum;
   int unsigned counted;
   int unsigned fs_run;
   int unsigned latch_code;
   bit [63:0]   log_tab[TAB_N+1];

   audio_level_meter uut (.*);

   initial forever #5 clock = ~clock;

   function automatic longint log2_q16(bit [63:0] x);
      int p;
      bit [63:0] f, rem, lo, hi;
      p = 0;
      for (int i = 0; i < 64; i++) if (x[i]) p = i;
      f = (x << (63 - p)) << 1;
      rem = {48'd0, f[55:40]};
      lo = log_tab[f[63:56]];
      hi = log_tab[int'(f[63:56]) + 1];
      return longint'(p) * alm_pkg::ONE_Q16 + longint'(lo + (((hi - lo) * rem) >> 16));
   endfunction

   function automatic longint db_q16(bit [63:0] x, int fbits);
      longint l, prod, d;
      bit [63:0] u;
      l = log2_q16(x) - longint'(fbits) * alm_pkg::ONE_Q16;
      prod = l * alm_pkg::DB_PER_LOG2_Q16;
      if (prod < 0) begin
         u = -prod;
         d = -longint'((u + 32768) >> 16);
      end else begin
         u = prod;
         d = longint'((u + 32768) >> 16);
      end
      return (d < alm_pkg::FLOOR_DB_Q16) ? longint'(alm_pkg::FLOOR_DB_Q16) : d;
   endfunction

   function automatic longint meter_curve(longint d);
      longint u, n;
      u = alm_pkg::ONE_Q16;
      if (d < -70 * u) return 0;
      if (d >= 0) return alm_pkg::ONE_Q16;
      if (d < -60 * u)      n = d + 70 * u;
      else if (d < -50 * u) n = 2 * (d + 60 * u) + 10 * u;
      else if (d < -40 * u) n = 3 * (d + 50 * u) + 30 * u;
      else if (d < -30 * u) n = 6 * (d + 40 * u) + 60 * u;
      else if (d < -20 * u) n = 8 * (d + 30 * u) + 120 * u;
      else                  n = 10 * (d + 20 * u) + 200 * u;
      return (n + alm_pkg::IEC_ROUND) / alm_pkg::IEC_DIVISOR;
   endfunction

   function automatic void clear_window();
      peak_mag = 0;
      mag_sum = 0;
      counted = 0;
      fs_run = 0;
      latch_code = alm_pkg::LATCH_NONE;
   endfunction

   // advance the window state by one accepted word, queue a level at window end
   function automatic void meter_take(sample_word_type w);
      bit [31:0] raw, mag;
      int unsigned lim;
      longint lvl;
      level_word_type e;
      raw = w.sample;
      mag = raw[31] ? (~raw + 1) : raw;
      if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
      lim = (win_limit > alm_pkg::MAX_WINDOW_DEF) ? alm_pkg::MAX_WINDOW_DEF : win_limit;
      if (counted < lim) begin
         counted++;
         if (mag > peak_mag) peak_mag = mag;
         if (latch_code != alm_pkg::LATCH_FULL) begin
            mag_sum += mag;
            if (mag >= 32'h1000_0000) begin
               if (fs_run < 15) fs_run++;
            end else begin
               fs_run = 0;
            end
            if (fs_run > 10) latch_code = alm_pkg::LATCH_FULL;
            else if (fs_run > 3) latch_code = alm_pkg::LATCH_HIGH;
         end
      end
      if (!w.last) return;
      if (mode_peak) begin
         lvl = (peak_mag == 0) ? longint'(alm_pkg::FLOOR_DB_Q16) : db_q16(peak_mag, 28);
         if (mode_iec) lvl = meter_curve(lvl);
      end else begin
         if (latch_code == alm_pkg::LATCH_FULL) lvl = alm_pkg::ONE_Q16;
         else if (latch_code == alm_pkg::LATCH_HIGH) lvl = alm_pkg::LEVEL_41_42;
         else if (counted > 0)
            lvl = longint'((mag_sum * 40) / (64'(counted) * 42 * 4096));
         else lvl = 0;
         if (mode_iec) lvl = (lvl > 0) ? meter_curve(db_q16(lvl, 16)) : 0;
      end
      e.level = lvl[alm_pkg::LEVEL_W-1:0];
      e.channel = w.channel;
      expected_levels.push_back(e);
      clear_window();
   endfunction

   // driver: hold the word until accepted, then maybe insert a gap
   always @(posedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            w.sample = req_sample_value;
            w.channel = req_channel;
            w.last = req_last_sample;
            meter_take(w);
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && !(gaps_on && $urandom_range(99) < 33)) begin
               w = pending_samples.pop_front();
               req_valid <= 1;
               req_sample_value <= w.sample;
               req_channel <= w.channel;
               req_last_sample <= w.last;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor: compare each level word with the oldest expectation
   always @(posedge clock) begin
      level_word_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 33);
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected level word %h ch %0d", rsp_level, rsp_level_channel);
            end else begin
               e = expected_levels.pop_front();
               if (rsp_level !== e.level || rsp_level_channel !== e.channel) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("level mismatch: exp %h ch %0d, got %h ch %0d",
                              e.level, e.channel, rsp_level, rsp_level_channel);
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
         $display("FAIL audio_level_meter");
         $finish;
      end
   end

   task automatic csr_write(alm_pkg::csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val[alm_pkg::CSR_W-1:0];
      case (idx)
         alm_pkg::CSR_PEAK_MODE:    mode_peak = val[0];
         alm_pkg::CSR_IEC_ENABLE:   mode_iec = val[0];
         alm_pkg::CSR_WINDOW_LIMIT: win_limit = val[alm_pkg::CSR_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic set_config(bit pk, bit iec, int unsigned lim);
      csr_write(alm_pkg::CSR_PEAK_MODE, pk);
      csr_write(alm_pkg::CSR_IEC_ENABLE, iec);
      csr_write(alm_pkg::CSR_WINDOW_LIMIT, lim);
   endtask

   task automatic push_word(logic [31:0] s, bit last);
      sample_word_type w;
      w.sample = s;
      w.channel = $urandom_range(255);
      w.last = last;
      pending_samples.push_back(w);
   endtask

   // wait for the meter to drain, then let the back end settle
   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_levels.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] random_sample();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h1000_0000 : 32'hF000_0000;
         2: return $urandom_range(32'h0FFF_FFFF);
         3: return -$urandom_range(32'h0FFF_FFFF);
         4: return $urandom_range(255);
         5: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom >> $urandom_range(31);
      endcase
   endfunction

   task automatic random_window();
      int len, run_at, run_len;
      logic [31:0] s;
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
      run_at = ($urandom_range(2) == 0) ? $urandom_range(len - 1) : len;
      run_len = $urandom_range(3, 14);
      for (int i = 0; i < len; i++) begin
         if (i >= run_at && i < run_at + run_len)
            s = $urandom_range(1) ? 32'h1000_0000 + $urandom_range(32'h0FFF_FFFF)
                                  : -(32'h1000_0000 + $urandom_range(32'h0FFF_FFFF));
         else
            s = random_sample();
         push_word(s, i == len - 1);
      end
   endtask

   initial begin
      int lim, nwin;
      bit [63:0] m;
      bit [31:0] y;
      for (int i = 0; i < TAB_N; i++) begin
         m = (64'd1 << 30) + (64'(i) << (30 - alm_pkg::LOG_TABLE_BITS_DEF));
         y = 0;
         for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               y[k] = 1;
            end
         end
         log_tab[i] = y;
      end
      log_tab[TAB_N] = alm_pkg::ONE_Q16;
      mode_peak = 0;
      mode_iec = 1;
      win_limit = 200;
      clear_window();

      repeat (6) @(posedge clock);
      reset <= 0;

      // directed: zero, extremes, full-scale edge, both latch levels
      push_word(32'h0, 1);
      push_word(32'h8000_0000, 1);
      push_word(32'h7FFF_FFFF, 1);
      push_word(32'h0FFF_FFFF, 0);
      push_word(32'h1000_0000, 1);
      for (int i = 0; i < 4; i++) push_word(32'hF000_0000, i == 3);
      for (int i = 0; i < 12; i++) push_word(32'h1000_0000, i == 11);
      drain();
      set_config(1, 1, 0);
      push_word(32'h7FFF_FFFF, 1);
      push_word(32'h0, 1);
      drain();
      set_config(1, 0, 2);
      push_word(32'h0, 0);
      push_word(32'h0, 0);
      push_word(32'h8000_0000, 1);
      push_word(32'h1, 1);
      drain();

      // random phases across register settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: lim = 256;
            1: lim = 511;
            2: lim = 1;
            3: lim = 0;
            4: lim = 300;
            default: lim = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 16);
         endcase
         set_config(ph[0], ph[1] ^ ph[2], lim);
         gaps_on = (ph != 6);
         nwin = 4;
         for (int i = 0; i < nwin; i++) random_window();
         if (ph == 5) begin
            // sender holds off until every level has come back
            while (pending_samples.size() > 0 || req_valid || expected_levels.size() > 0)
               @(posedge clock);
            for (int i = 0; i < nwin; i++) random_window();
         end
         drain();
      end

      if (mismatches == 0 && expected_levels.size() == 0) begin
         $display("PASS audio_level_meter");
      end else begin
         $display("FAIL audio_level_meter");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/alm_pkg.sv
sv/alm_front.sv
sv/alm_fifo.sv
sv/alm_div.sv
sv/alm_back.sv
sv/audio_level_meter.sv
tb/tb_audio_level_meter.sv
